// ===== design/pfd_pkg.sv =====
package pfd_pkg;

	// One input transaction: a raw byte of the datagram and its last-byte flag.
	typedef struct packed {
		logic [7:0] wire_byte;
		logic       end_of_datagram;
	} in_item_t;

	// One result transaction: either a payload byte or the closing status item.
	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [7:0]  frame_sequence;
		logic [15:0] frame_target;
		logic [7:0]  frame_command;
		logic [15:0] declared_length;
		logic [2:0]  status;
		logic        is_final;
	} out_item_t;

	// Work handed from the front to the back: an optional decoded group and
	// an optional closing status, both raised by the same input byte.
	typedef struct packed {
		logic [7:0][7:0] data;
		logic [3:0]      cnt;
		logic            first;
		logic            has_final;
		logic [2:0]      pre_status;
		logic [7:0]      seq;
		logic [15:0]     body_size;
	} job_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_START    = 3'd2;
	localparam logic [2:0] ST_LENGTH   = 3'd3;
	localparam logic [2:0] ST_END      = 3'd4;
	localparam logic [2:0] ST_CHECKSUM = 3'd5;
	localparam logic [2:0] ST_PAYLEN   = 3'd6;

	localparam logic [7:0]  START_MARK  = 8'h5b;
	localparam logic [7:0]  END_MARK    = 8'h5d;
	localparam logic [7:0]  PLAIN_HI    = 8'hff;
	localparam logic [7:0]  CMD_PLAIN_A = 8'h80;
	localparam logic [7:0]  CMD_PLAIN_B = 8'h81;
	localparam logic [7:0]  CMD_PLAIN_C = 8'hd0;
	localparam logic [7:0]  CMD_PLAIN_D = 8'hd1;
	localparam logic [16:0] COUNT_MAX   = 17'h1ffff;
	localparam logic [16:0] MIN_LEN     = 17'd11;
	localparam logic [3:0]  HEADER_LEN  = 4'd5;
	localparam logic [3:0]  GROUP_LEN   = 4'd8;

	localparam logic [2:0] PERM [8] = '{3'd7, 3'd6, 3'd4, 3'd1, 3'd3, 3'd2, 3'd5, 3'd0};

	function automatic logic [7:0] unpermute_bits(input logic [7:0] e);
		logic [7:0] p;
		p = '0;
		for (int b = 0; b < 8; b++) begin
			p[PERM[b]] = e[b];
		end
		return p;
	endfunction

	function automatic logic needs_scramble(input logic [7:0] tgt_hi, input logic [7:0] cmd);
		logic plain_cmd;
		plain_cmd = cmd inside {CMD_PLAIN_A, CMD_PLAIN_B, CMD_PLAIN_C, CMD_PLAIN_D};
		return (tgt_hi != PLAIN_HI) || !plain_cmd;
	endfunction

	// When scr is set, a full group is reordered and bit-permuted, a short one bit-permuted only.
	function automatic logic [7:0][7:0] descramble(input logic [7:0][7:0] g,
		input logic [3:0] cnt, input logic scr);
		logic [7:0][7:0] p;
		p = g;
		if (scr) begin
			for (int i = 0; i < 8; i++) begin
				if (cnt == GROUP_LEN) begin
					p[PERM[i]] = unpermute_bits(g[i]);
				end else begin
					p[i] = unpermute_bits(g[i]);
				end
			end
		end
		return p;
	endfunction

endpackage

// ===== design/pfd_front.sv =====
module pfd_front import pfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     acc,
	input  in_item_t item,
	output logic     job_push,
	output job_t     job
);

	logic [16:0] pos_q;
	logic [7:0]  sum_q;
	logic [7:0]  prev_q;
	logic        start_q;
	logic [15:0] body_q;
	logic [7:0]  seq_q;
	logic        scr_q;
	logic [7:0]  head_hi_q;
	logic [2:0]  fill_q;
	logic        notfirst_q;
	logic [7:0]  store_q [8];

	logic [7:0]      wb;
	logic            last;
	logic [16:0]     bi;
	logic            in_body;
	logic            last_body;
	logic            grp_done;
	logic [3:0]      cnt;
	logic            scr_now;
	logic [7:0][7:0] grp;
	logic [16:0]     len;
	logic [2:0]      pre;

	always_comb begin
		wb        = item.wire_byte;
		last      = item.end_of_datagram;
		bi        = pos_q - 17'd4;
		in_body   = (pos_q >= 17'd4) && (bi < {1'b0, body_q});
		last_body = (bi + 17'd1) == {1'b0, body_q};
		grp_done  = in_body && ((fill_q == 3'd7) || last_body);
		cnt       = {1'b0, fill_q} + 4'd1;
		scr_now   = (in_body && (bi == 17'd2)) ? needs_scramble(head_hi_q, wb) : scr_q;
		for (int i = 0; i < 8; i++) begin
			grp[i] = (3'(i) == fill_q) ? wb : store_q[i];
		end

		len = (pos_q != COUNT_MAX) ? pos_q + 17'd1 : COUNT_MAX;
		if (len < MIN_LEN) begin
			pre = ST_SHORT;
		end else if (!start_q) begin
			pre = ST_START;
		end else if (len != {1'b0, body_q} + 17'd6) begin
			pre = ST_LENGTH;
		end else if (prev_q != END_MARK) begin
			pre = ST_END;
		end else if (sum_q != wb) begin
			pre = ST_CHECKSUM;
		end else begin
			pre = ST_OK;
		end

		job.data       = descramble(grp, cnt, scr_now);
		job.cnt        = grp_done ? cnt : 4'd0;
		job.first      = !notfirst_q;
		job.has_final  = last;
		job.pre_status = pre;
		job.seq        = seq_q;
		job.body_size  = body_q;
		job_push       = acc && (grp_done || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			sum_q      <= '0;
			prev_q     <= '0;
			start_q    <= 1'b0;
			body_q     <= '0;
			seq_q      <= '0;
			scr_q      <= 1'b0;
			head_hi_q  <= '0;
			fill_q     <= '0;
			notfirst_q <= 1'b0;
		end else if (acc) begin
			if (last) begin
				pos_q      <= '0;
				sum_q      <= '0;
				prev_q     <= '0;
				start_q    <= 1'b0;
				body_q     <= '0;
				seq_q      <= '0;
				scr_q      <= 1'b0;
				head_hi_q  <= '0;
				fill_q     <= '0;
				notfirst_q <= 1'b0;
			end else begin
				sum_q  <= sum_q + wb;
				prev_q <= wb;
				if (pos_q != COUNT_MAX) begin
					pos_q <= pos_q + 17'd1;
				end
				if (pos_q == 17'd0) begin
					start_q <= (wb == START_MARK);
				end else if (pos_q == 17'd1) begin
					seq_q <= wb;
				end else if (pos_q == 17'd2) begin
					body_q <= {wb, 8'h00};
				end else if (pos_q == 17'd3) begin
					body_q <= {body_q[15:8], wb};
				end else if (in_body) begin
					if (bi == 17'd0) begin
						head_hi_q <= wb;
					end
					scr_q  <= scr_now;
					fill_q <= grp_done ? 3'd0 : fill_q + 3'd1;
					if (grp_done) begin
						notfirst_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_body) begin
			store_q[fill_q] <= wb;
		end
	end

endmodule

// ===== design/pfd_job_fifo.sv =====
module pfd_job_fifo import pfd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	output logic full,
	input  logic rd_en,
	output logic nonempty,
	output job_t rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== design/pfd_back.sv =====
module pfd_back import pfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_avail,
	input  job_t      job,
	output logic      job_take,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	job_t      cur_q;
	logic      cur_valid_q;
	logic [3:0] idx_q;
	logic      fin_pend_q;
	logic [15:0] tgt_q;
	logic [7:0]  cmd_q;
	logic [15:0] stated_q;
	out_item_t out_q;
	logic      out_valid_q;

	logic      is_pay;
	logic      remaining;
	logic      out_free;
	logic      emit;
	logic      last_item;
	logic      load;
	logic [2:0] st;
	out_item_t item;

	always_comb begin
		is_pay    = idx_q < cur_q.cnt;
		remaining = cur_valid_q && (is_pay || fin_pend_q);
		out_free  = !out_valid_q || pop;
		emit      = remaining && out_free;
		last_item = is_pay ? ((idx_q + 4'd1 >= cur_q.cnt) && !fin_pend_q) : 1'b1;
		load      = job_avail && (!remaining || (emit && last_item));
		job_take  = load;

		st = cur_q.pre_status;
		if ((cur_q.pre_status == ST_OK) &&
			({1'b0, cur_q.body_size} != {1'b0, stated_q} + 17'd5)) begin
			st = ST_PAYLEN;
		end

		item = '0;
		if (is_pay) begin
			item.payload_byte = cur_q.data[idx_q[2:0]];
		end else begin
			item.is_final = 1'b1;
			item.status   = st;
			if ((st == ST_OK) || (st == ST_PAYLEN)) begin
				item.frame_sequence  = cur_q.seq;
				item.frame_target    = tgt_q;
				item.frame_command   = cmd_q;
				item.declared_length = stated_q;
			end
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			fin_pend_q  <= 1'b0;
			tgt_q       <= '0;
			cmd_q       <= '0;
			stated_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end

			if (emit && is_pay) begin
				idx_q <= idx_q + 4'd1;
			end
			if (emit && !is_pay) begin
				fin_pend_q <= 1'b0;
				tgt_q      <= '0;
				cmd_q      <= '0;
				stated_q   <= '0;
			end
			if (cur_valid_q && (!remaining || (emit && last_item))) begin
				cur_valid_q <= 1'b0;
			end

			if (load) begin
				cur_valid_q <= 1'b1;
				idx_q       <= job.first ? HEADER_LEN : 4'd0;
				fin_pend_q  <= job.has_final;
				// The first group of a datagram carries the decoded header.
				if (job.first && (job.cnt != 4'd0)) begin
					tgt_q    <= {job.data[0], (job.cnt >= 4'd2) ? job.data[1] : 8'h00};
					cmd_q    <= (job.cnt >= 4'd3) ? job.data[2] : 8'h00;
					stated_q <= {(job.cnt >= 4'd4) ? job.data[3] : 8'h00,
						(job.cnt >= 4'd5) ? job.data[4] : 8'h00};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= job;
		end
		if (emit) begin
			out_q <= item;
		end
	end

endmodule

// ===== design/permuted_frame_decoder.sv =====
// Permuted frame decoder. Datagram bytes enter one per clock as queue-style
// transactions (push/full) and decoded results leave the same way
// (empty/pop). A datagram is the 0x5b start marker, a sequence byte, a
// 16-bit big-endian body length, the body, the 0x5d end marker and an
// additive checksum byte; the caller flags its last byte. Body bytes are
// descrambled in groups of eight, and each completed group yields its
// payload bytes as separate result transactions (the first five decoded
// body bytes form the header and are not emitted as payload). The last
// byte yields one closing transaction with is_final set, a status and,
// unless the status is a framing error, the header; a nonzero status means
// the payload already delivered must be discarded. Input bytes are taken
// at one per cycle: the front end does the per-byte checks and group
// collection as each byte is taken, and a completed group or closing
// status goes into a job queue of JOB_DEPTH entries. The back end drains
// one result per cycle from that queue while pop keeps its output free, so
// a full group after the first yields eight payload results; input stalls
// (full high) only while the job queue is full. A completed job reaches
// the outputs through the job queue, current-job and output registers.
module permuted_frame_decoder import pfd_pkg::*; #(
	parameter int JOB_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic acc;
	logic job_push;
	job_t job_in;
	logic job_avail;
	logic job_take;
	job_t job_out;

	// A byte is taken whenever the job queue has room, even if that byte
	// ends up raising no job.
	assign acc = push && !full;

	pfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.item     (item),
		.job_push (job_push),
		.job      (job_in)
	);

	pfd_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_job_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_push),
		.wr_data  (job_in),
		.full     (full),
		.rd_en    (job_take),
		.nonempty (job_avail),
		.rd_data  (job_out)
	);

	// The back end emits the payload of each group in order, then the
	// closing status transaction, through a registered output stage.
	pfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (job_avail),
		.job       (job_out),
		.job_take  (job_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== design/pfd_checker.sv =====
module pfd_checker import pfd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	// A waiting result that is not taken stays on the ports unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("pending result changed before it was taken");

	// Payload transactions carry no header or status.
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.is_final |-> result.status == ST_OK &&
			result.frame_sequence == 8'h00 && result.frame_target == 16'h0000 &&
			result.frame_command == 8'h00 && result.declared_length == 16'h0000)
		else $error("payload transaction carries header fields");

	// Early framing errors report an empty header, and payload bytes are zero.
	a_error_header: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.is_final && (result.status == ST_SHORT ||
			result.status == ST_START || result.status == ST_LENGTH ||
			result.status == ST_END || result.status == ST_CHECKSUM) |->
			result.frame_sequence == 8'h00 && result.frame_target == 16'h0000 &&
			result.frame_command == 8'h00 && result.declared_length == 16'h0000 &&
			result.payload_byte == 8'h00)
		else $error("framing error reported with header fields");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.is_final |-> result.status != 3'd7 && result.payload_byte == 8'h00)
		else $error("closing transaction with invalid status or payload");

endmodule

bind permuted_frame_decoder pfd_checker u_pfd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
